// ----- hw/rtl/bit_run_length_text_encoder_core_assert.svh -----
// Assertion macros shared by the bit run-length text encoder RTL.
`ifndef BIT_RUN_LENGTH_TEXT_ENCODER_CORE_ASSERT_SVH
`define BIT_RUN_LENGTH_TEXT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/brle_pkg.sv -----
// Types and constants of the bit run-length text encoder.
`timescale 1ns / 1ps

package brle_pkg;

    // Character sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EOL,
        ST_DIG,
        ST_LET,
        ST_FIN
    } state_t;

    localparam logic [7:0] CHAR_H    = 8'd72;
    localparam logic [7:0] CHAR_L    = 8'd76;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NONE = 8'd0;

    localparam int unsigned LINE_BUFFER  = 72;
    localparam int unsigned RESULT_SLOTS = 9;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIGITS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 1'b1;

    localparam logic [3:0] MAX_DIGITS_RESET  = 4'd6;
    localparam logic [6:0] LINE_LENGTH_RESET = 7'd72;

endpackage

// ----- hw/rtl/brle_if.sv -----
// Handshake channel interfaces of the bit run-length text encoder.
`timescale 1ns / 1ps

interface brle_in_if;
    logic valid;
    logic ready;
    logic action;
    logic sample_bit;

    modport source (output valid, output action, output sample_bit, input ready);
    modport sink (input valid, input action, input sample_bit, output ready);
endinterface

interface brle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;
    logic       last;

    modport source (output valid, output char_code, output end_of_line, output last,
                    input ready);
    modport sink (input valid, input char_code, input end_of_line, input last,
                  output ready);
endinterface

interface brle_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [brle_pkg::CFG_INDEX_W-1:0] index;
    logic [brle_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bit_run_length_text_encoder_core.sv -----
// Top level of the bit run-length text encoder: run counter and character sequencer.
`timescale 1ns / 1ps
//
//  channel   modport  payload                              item
//  --------  -------  -----------------------------------  ---------------------------
//  samples   sink     action, sample_bit                   one sample or a flush
//  tokens    source   char_code, end_of_line, last         one character or line end
//  cfg       sink     index (0 max_digits, 1 line_length)  one register write
//
//  An input item is taken only while the sequencer is idle; the BCD run count
//  is updated as the item is taken. Each result then passes through the character
//  sequencer, which reads digits out of a shift register one digit per cycle
//  while the tokens channel is not stalled.
//  Reset (rst_n low, asynchronous) clears the run and the line position and loads
//  max_digits = 6 and line_length = 72. No clearing pass is needed.
//  A stalled tokens channel holds the sequencer; samples is taken again only once
//  the sequencer has handed its last character to the output register.

`include "bit_run_length_text_encoder_core_assert.svh"

module bit_run_length_text_encoder_core
#(
    parameter int DIGIT_LIMIT = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    brle_in_if.sink       samples,
    brle_out_if.source    tokens,
    brle_cfg_if.sink      cfg
);

    // Stored digits: the count never passes the result-slot cap
    localparam int NDIG = (DIGIT_LIMIT < int'(brle_pkg::RESULT_SLOTS) - 3) ?
                          DIGIT_LIMIT : int'(brle_pkg::RESULT_SLOTS) - 3;
    localparam int CW   = 4 * NDIG;
    localparam int LW   = $clog2(NDIG + 1);
    localparam logic [3:0] NDIG4 = 4'(NDIG);

    // Configuration
    logic [3:0] max_digits_reg;
    logic [6:0] line_length_reg;

    // Run state
    logic          run_level_reg, run_level_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    line_pos_reg, line_pos_next;

    // Sequencer
    brle_pkg::state_t state_reg, state_next;
    logic          tok_level_reg, tok_level_next;
    logic          flush_reg, flush_next;
    logic [CW-1:0] shift_reg, shift_next;
    logic [LW-1:0] dig_left_reg, dig_left_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg, char_next;
    logic       eol_reg, eol_next;
    logic       last_reg, last_next;

    // Add one to a BCD count, one digit at a time from the bottom
    function automatic logic [CW-1:0] bcd_inc(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        logic          carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
            if (carry) begin
                if (r[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end
                else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Number of significant digits
    function automatic logic [LW-1:0] sig_len(input logic [CW-1:0] v);
        logic [LW-1:0] len;
        len = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (v[4*i +: 4] != 4'd0) begin
                len = LW'(i + 1);
            end
        end
        return len;
    endfunction

    // Count at or above the all-nines value of eff digits
    function automatic logic at_limit(input logic [CW-1:0] v, input logic [3:0] eff);
        logic hi_nz;
        logic all9;
        hi_nz = 1'b0;
        all9  = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
            if (4'(i) >= eff) begin
                hi_nz = hi_nz | (v[4*i +: 4] != 4'd0);
            end
            else begin
                all9 = all9 & (v[4*i +: 4] == 4'd9);
            end
        end
        return hi_nz | all9;
    endfunction

    function automatic logic bcd_ok(input logic [CW-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
            ok = ok & (v[4*i +: 4] <= 4'd9);
        end
        return ok;
    endfunction

    // Effective digit count and line threshold
    logic [3:0] md_clamp;
    logic [3:0] eff_digits;
    logic [6:0] line_eff;
    logic [6:0] room;
    logic [6:0] threshold;
    logic       eol_first;

    assign md_clamp   = (max_digits_reg == 4'd0) ? 4'd1 : max_digits_reg;
    assign eff_digits = (md_clamp > NDIG4) ? NDIG4 : md_clamp;
    assign line_eff   = (line_length_reg > 7'(brle_pkg::LINE_BUFFER)) ?
                        7'(brle_pkg::LINE_BUFFER) : line_length_reg;
    assign room       = {3'd0, eff_digits} + 7'd2;
    assign threshold  = (line_eff > room) ? line_eff - room : 7'd0;
    assign eol_first  = line_pos_reg >= threshold;

    // Handshakes
    logic in_acc;
    logic out_free;

    assign samples.ready = (state_reg == brle_pkg::ST_IDLE);
    assign in_acc        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || tokens.ready;
    assign cfg.ready     = 1'b1;

    assign tokens.valid       = out_valid_reg;
    assign tokens.char_code   = char_reg;
    assign tokens.end_of_line = eol_reg;
    assign tokens.last        = last_reg;

    // Run update at accept
    logic [CW-1:0] inc_val;
    logic [CW-1:0] tok_val;
    logic [LW-1:0] tok_len;
    logic          tok_go;
    logic          run_open;

    assign inc_val  = bcd_inc(count_reg);
    assign run_open = (count_reg != '0);

    always_comb
    begin
        run_level_next = run_level_reg;
        count_next     = count_reg;
        line_pos_next  = line_pos_reg;
        state_next     = state_reg;
        tok_level_next = tok_level_reg;
        flush_next     = flush_reg;
        shift_next     = shift_reg;
        dig_left_next  = dig_left_reg;
        out_valid_next = out_valid_reg && !tokens.ready;
        char_next      = char_reg;
        eol_next       = eol_reg;
        last_next      = last_reg;
        tok_go         = 1'b0;
        tok_val        = count_reg;
        tok_len        = '0;

        case (state_reg)
            brle_pkg::ST_IDLE:
            begin
                if (in_acc) begin
                    flush_next = samples.action;
                    if (samples.action) begin
                        // Flush: close any open run, then clear
                        tok_go         = run_open;
                        run_level_next = 1'b0;
                        count_next     = '0;
                    end
                    else if (!run_open) begin
                        run_level_next = samples.sample_bit;
                        count_next     = CW'(1);
                    end
                    else if (samples.sample_bit == run_level_reg) begin
                        // Cut the run once it reaches all nines
                        if (at_limit(inc_val, eff_digits)) begin
                            tok_go     = 1'b1;
                            tok_val    = inc_val;
                            count_next = '0;
                        end
                        else begin
                            count_next = inc_val;
                        end
                    end
                    else begin
                        tok_go         = 1'b1;
                        run_level_next = samples.sample_bit;
                        count_next     = CW'(1);
                    end

                    tok_len        = (tok_val == CW'(1)) ? '0 : sig_len(tok_val);
                    tok_level_next = run_level_reg;
                    dig_left_next  = tok_len;
                    // Align the top significant digit to the shift-out end
                    shift_next     = tok_val << (4 * (NDIG - int'(sig_len(tok_val))));

                    if (tok_go) begin
                        if (eol_first) begin
                            state_next = brle_pkg::ST_EOL;
                        end
                        else if (tok_len != '0) begin
                            state_next = brle_pkg::ST_DIG;
                        end
                        else begin
                            state_next = brle_pkg::ST_LET;
                        end
                    end
                    else if (samples.action) begin
                        state_next = brle_pkg::ST_FIN;
                    end
                end
            end

            brle_pkg::ST_EOL:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    char_next      = brle_pkg::CHAR_NONE;
                    eol_next       = 1'b1;
                    last_next      = 1'b0;
                    line_pos_next  = 7'd0;
                    state_next     = (dig_left_reg != '0) ? brle_pkg::ST_DIG :
                                                            brle_pkg::ST_LET;
                end
            end

            brle_pkg::ST_DIG:
            begin
                if (out_free) begin
                    // Shift out one digit, most significant first
                    out_valid_next = 1'b1;
                    char_next      = brle_pkg::CHAR_ZERO + {4'd0, shift_reg[CW-1 -: 4]};
                    eol_next       = 1'b0;
                    last_next      = 1'b0;
                    line_pos_next  = line_pos_reg + 7'd1;
                    shift_next     = shift_reg << 4;
                    dig_left_next  = dig_left_reg - LW'(1);
                    state_next     = (dig_left_reg == LW'(1)) ? brle_pkg::ST_LET :
                                                                brle_pkg::ST_DIG;
                end
            end

            brle_pkg::ST_LET:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    char_next      = tok_level_reg ? brle_pkg::CHAR_H : brle_pkg::CHAR_L;
                    eol_next       = 1'b0;
                    last_next      = !flush_reg;
                    line_pos_next  = line_pos_reg + 7'd1;
                    state_next     = flush_reg ? brle_pkg::ST_FIN : brle_pkg::ST_IDLE;
                end
            end

            brle_pkg::ST_FIN:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    char_next      = brle_pkg::CHAR_NONE;
                    eol_next       = 1'b1;
                    last_next      = 1'b1;
                    line_pos_next  = 7'd0;
                    state_next     = brle_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = brle_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= brle_pkg::ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_digits_reg  <= brle_pkg::MAX_DIGITS_RESET;
            line_length_reg <= brle_pkg::LINE_LENGTH_RESET;
            run_level_reg   <= 1'b0;
            count_reg       <= '0;
            line_pos_reg    <= 7'd0;
            flush_reg       <= 1'b0;
            dig_left_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    brle_pkg::REG_MAX_DIGITS:  max_digits_reg  <= cfg.data[3:0];
                    brle_pkg::REG_LINE_LENGTH: line_length_reg <= cfg.data[6:0];
                    default:                   max_digits_reg  <= max_digits_reg;
                endcase
            end
            run_level_reg <= run_level_next;
            count_reg     <= count_next;
            line_pos_reg  <= line_pos_next;
            flush_reg     <= flush_next;
            dig_left_reg  <= dig_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tok_level_reg <= tok_level_next;
        shift_reg     <= shift_next;
        char_reg      <= char_next;
        eol_reg       <= eol_next;
        last_reg      <= last_next;
    end

    `BRLE_ASSERT_IMPL(a_eol_no_char, clk, rst_n,
        tokens.valid && tokens.end_of_line, tokens.char_code == brle_pkg::CHAR_NONE,
        "line end item carries a character")
    `BRLE_ASSERT_IMPL(a_last_is_letter, clk, rst_n,
        tokens.valid && tokens.last && !tokens.end_of_line,
        tokens.char_code == brle_pkg::CHAR_H || tokens.char_code == brle_pkg::CHAR_L,
        "last character of a token is not a level letter")
    `BRLE_ASSERT_IMPL(a_digits_left, clk, rst_n,
        state_reg == brle_pkg::ST_DIG, dig_left_reg != '0,
        "digit state with no digits left")
    `BRLE_ASSERT_IMPL(a_count_bcd, clk, rst_n,
        1'b1, bcd_ok(count_reg),
        "run count holds a digit above nine")

endmodule
